// ===== src/mrt_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the region table
package mrt_pkg;

  localparam int ENTRIES_DEFAULT = 64;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_PROT   = 2'd1;
  localparam logic [1:0] ACT_UNMAP  = 2'd2;
  localparam logic [1:0] ACT_LOOKUP = 2'd3;

  localparam logic [2:0] KIND_SHARED = 3'd3;

  localparam logic [2:0] SCAN_FIND   = 3'd0;
  localparam logic [2:0] SCAN_MATCH  = 3'd1;
  localparam logic [2:0] SCAN_FREE   = 3'd2;
  localparam logic [2:0] SCAN_PROT   = 3'd3;
  localparam logic [2:0] SCAN_UNMAP  = 3'd4;
  localparam logic [2:0] SCAN_LOOKUP = 3'd5;

  typedef struct packed {
    logic       load;
    logic       scan_go;
    logic [2:0] scan_op;
    logic       key_end;
    logic       ins_split;
    logic       wr_prot;
    logic       wr_new;
    logic       wr_left;
    logic       out_load;
    logic       status;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic split_need;
  } sts_t;

endpackage

// ===== src/mrt_datapath.sv =====
// region store, scan engine and result registers
module mrt_datapath #(
  parameter int ENTRIES = mrt_pkg::ENTRIES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  mrt_pkg::cmd_t cmd,
  input  logic [15:0]   owner,
  input  logic [63:0]   base_addr,
  input  logic [63:0]   length,
  input  logic [2:0]    prot,
  input  logic [2:0]    kind,
  output mrt_pkg::sts_t sts,
  output logic          status,
  output logic          hit,
  output logic [2:0]    hit_prot,
  output logic [2:0]    hit_kind,
  output logic          is_shared
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  logic [15:0] m_owner  [ENTRIES];
  logic [63:0] m_base   [ENTRIES];
  logic [63:0] m_length [ENTRIES];
  logic [2:0]  m_prot   [ENTRIES];
  logic [2:0]  m_kind   [ENTRIES];
  logic [ENTRIES-1:0] valid;

  logic [15:0] req_own;
  logic [63:0] req_a;
  logic [63:0] req_end;
  logic [2:0]  req_prot;
  logic [63:0] key_addr;
  logic [63:0] ins_base;
  logic [63:0] ins_len;
  logic [2:0]  ins_prot;
  logic [2:0]  ins_kind;
  logic [IW-1:0] v_idx;
  logic [63:0] v_base;
  logic [63:0] v_len;
  logic [2:0]  v_prot;
  logic [2:0]  v_kind;
  logic [63:0] left;
  logic [IW-1:0] f_idx;
  logic        found;
  logic        lk_hit;
  logic [2:0]  lk_prot;
  logic [2:0]  lk_kind;
  logic        lk_shared;

  logic          busy;
  logic          phase;
  logic [IW-1:0] cnt;
  logic [2:0]    op;
  logic          done;

  logic [15:0] rd_owner;
  logic [63:0] rd_base;
  logic [63:0] rd_len;
  logic [2:0]  rd_prot;
  logic [2:0]  rd_kind;

  logic        eval;
  logic        own_ok;
  logic [63:0] rd_end;
  logic        contain;
  logic        ident;
  logic        overlap;
  logic        hit_now;
  logic        first_type;
  logic        finish;

  always_comb begin
    eval    = busy && phase;
    own_ok  = valid[cnt] && (rd_owner == req_own);
    rd_end  = rd_base + rd_len;
    contain = own_ok && (key_addr >= rd_base) && (key_addr < rd_end);
    ident   = own_ok && (rd_base == ins_base) && (rd_len == ins_len) && (rd_kind == ins_kind);
    overlap = own_ok && !((rd_end <= req_a) || (rd_base >= req_end));
    unique case (op)
      mrt_pkg::SCAN_FIND:   hit_now = contain;
      mrt_pkg::SCAN_MATCH:  hit_now = ident;
      mrt_pkg::SCAN_FREE:   hit_now = !valid[cnt];
      mrt_pkg::SCAN_PROT:   hit_now = overlap;
      mrt_pkg::SCAN_UNMAP:  hit_now = overlap;
      mrt_pkg::SCAN_LOOKUP: hit_now = contain;
      default:              hit_now = 1'b0;
    endcase
    first_type = (op == mrt_pkg::SCAN_FIND) || (op == mrt_pkg::SCAN_MATCH) ||
                 (op == mrt_pkg::SCAN_FREE);
    finish = eval && ((cnt == LAST) || (first_type && hit_now));
  end

  // scan engine
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
      op    <= mrt_pkg::SCAN_FIND;
      done  <= 1'b0;
    end else begin
      done <= finish;
      if (cmd.scan_go) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
        op    <= cmd.scan_op;
      end else if (busy) begin
        phase <= !phase;
        if (phase) begin
          if (finish) begin
            busy <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
      end
    end
  end

  // registered memory read
  always_ff @(posedge clk) begin
    rd_owner <= m_owner[cnt];
    rd_base  <= m_base[cnt];
    rd_len   <= m_length[cnt];
    rd_prot  <= m_prot[cnt];
    rd_kind  <= m_kind[cnt];
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      m_owner[f_idx] <= req_own;
      m_base[f_idx]  <= ins_base;
      m_kind[f_idx]  <= ins_kind;
    end
    if (cmd.wr_new) begin
      m_length[f_idx] <= ins_len;
    end else if (cmd.wr_left) begin
      m_length[v_idx] <= left;
    end
    if (cmd.wr_new || cmd.wr_prot) begin
      m_prot[f_idx] <= ins_prot;
    end else if (eval && hit_now && (op == mrt_pkg::SCAN_PROT)) begin
      m_prot[cnt] <= req_prot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.wr_new) begin
      valid[f_idx] <= 1'b1;
    end else if (eval && hit_now && (op == mrt_pkg::SCAN_UNMAP)) begin
      valid[cnt] <= 1'b0;
    end
  end

  // request, key and scan result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      lk_hit    <= 1'b0;
      lk_shared <= 1'b0;
    end else begin
      if (cmd.load) begin
        lk_hit    <= 1'b0;
        lk_shared <= 1'b0;
      end
      if (cmd.scan_go) begin
        found <= 1'b0;
      end else if (eval && hit_now && !found) begin
        found <= 1'b1;
        if (op == mrt_pkg::SCAN_LOOKUP) begin
          lk_hit <= 1'b1;
        end
      end
      if (eval && contain && (op == mrt_pkg::SCAN_LOOKUP) &&
          (rd_kind == mrt_pkg::KIND_SHARED)) begin
        lk_shared <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_own  <= owner;
      req_a    <= base_addr;
      req_end  <= base_addr + length;
      req_prot <= prot;
      key_addr <= base_addr;
      ins_base <= base_addr;
      ins_len  <= length;
      ins_prot <= prot;
      ins_kind <= kind;
      lk_prot  <= '0;
      lk_kind  <= '0;
    end else begin
      if (cmd.key_end) begin
        key_addr <= req_end;
      end
      if (cmd.ins_split) begin
        ins_base <= key_addr;
        ins_len  <= v_len - left;
        ins_prot <= v_prot;
        ins_kind <= v_kind;
      end
    end
    if (eval && hit_now && !found) begin
      f_idx <= cnt;
      if (op == mrt_pkg::SCAN_FIND) begin
        v_idx  <= cnt;
        v_base <= rd_base;
        v_len  <= rd_len;
        v_prot <= rd_prot;
        v_kind <= rd_kind;
        left   <= key_addr - rd_base;
      end
      if (op == mrt_pkg::SCAN_LOOKUP) begin
        lk_prot <= rd_prot;
        lk_kind <= rd_kind;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status    <= cmd.status;
      hit       <= lk_hit;
      hit_prot  <= lk_prot;
      hit_kind  <= lk_kind;
      is_shared <= lk_shared;
    end
  end

  always_comb begin
    sts.scan_done  = done;
    sts.found      = found;
    sts.split_need = found && (key_addr != v_base);
  end

  a_go_idle: assert property (@(posedge clk) disable iff (rst) cmd.scan_go |-> !busy)
    else $error("scan started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("scan done while still busy");
  a_wr_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_new || cmd.wr_prot || cmd.wr_left) |-> !busy)
    else $error("single write during scan");

endmodule

// ===== src/mrt_ctrl.sv =====
// action sequencer driving the scan engine and writes
module mrt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    action,
  output logic          out_valid,
  input  logic          out_stall,
  input  mrt_pkg::sts_t sts,
  output mrt_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISP      = 4'd1;
  localparam logic [3:0] S_ADD_MATCH = 4'd2;
  localparam logic [3:0] S_ADD_FREE  = 4'd3;
  localparam logic [3:0] S_SP_FIND   = 4'd4;
  localparam logic [3:0] S_SP_INS    = 4'd5;
  localparam logic [3:0] S_SP_MATCH  = 4'd6;
  localparam logic [3:0] S_SP_FREE   = 4'd7;
  localparam logic [3:0] S_SP_LEFT   = 4'd8;
  localparam logic [3:0] S_APPLY     = 4'd9;
  localparam logic [3:0] S_LOOK      = 4'd10;
  localparam logic [3:0] S_RESP      = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] act, act_next;
  logic       second, second_next;
  logic       fail, fail_next;
  logic       accept;
  logic       next_split;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next  = state;
    act_next    = act;
    second_next = second;
    fail_next   = fail;
    next_split  = 1'b0;
    cmd         = '0;
    cmd.scan_op = mrt_pkg::SCAN_FIND;
    cmd.status  = fail;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load    = 1'b1;
          act_next    = action;
          second_next = 1'b0;
          fail_next   = 1'b0;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.scan_go = 1'b1;
        unique case (act)
          mrt_pkg::ACT_ADD: begin
            cmd.scan_op = mrt_pkg::SCAN_MATCH;
            state_next  = S_ADD_MATCH;
          end
          mrt_pkg::ACT_LOOKUP: begin
            cmd.scan_op = mrt_pkg::SCAN_LOOKUP;
            state_next  = S_LOOK;
          end
          default: begin
            cmd.scan_op = mrt_pkg::SCAN_FIND;
            state_next  = S_SP_FIND;
          end
        endcase
      end
      S_ADD_MATCH: begin
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.wr_prot = 1'b1;
            state_next  = S_RESP;
          end else begin
            cmd.scan_go = 1'b1;
            cmd.scan_op = mrt_pkg::SCAN_FREE;
            state_next  = S_ADD_FREE;
          end
        end
      end
      S_ADD_FREE: begin
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.wr_new = 1'b1;
          end else begin
            fail_next = 1'b1;
          end
          state_next = S_RESP;
        end
      end
      S_SP_FIND: begin
        if (sts.scan_done) begin
          if (sts.split_need) begin
            cmd.ins_split = 1'b1;
            state_next    = S_SP_INS;
          end else begin
            next_split = 1'b1;
          end
        end
      end
      S_SP_INS: begin
        cmd.scan_go = 1'b1;
        cmd.scan_op = mrt_pkg::SCAN_MATCH;
        state_next  = S_SP_MATCH;
      end
      S_SP_MATCH: begin
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.wr_prot = 1'b1;
            state_next  = S_SP_LEFT;
          end else begin
            cmd.scan_go = 1'b1;
            cmd.scan_op = mrt_pkg::SCAN_FREE;
            state_next  = S_SP_FREE;
          end
        end
      end
      S_SP_FREE: begin
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.wr_new = 1'b1;
            state_next = S_SP_LEFT;
          end else if (act == mrt_pkg::ACT_PROT) begin
            fail_next  = 1'b1;
            state_next = S_RESP;
          end else begin
            next_split = 1'b1;
          end
        end
      end
      S_SP_LEFT: begin
        cmd.wr_left = 1'b1;
        next_split  = 1'b1;
      end
      S_APPLY: begin
        if (sts.scan_done) begin
          state_next = S_RESP;
        end
      end
      S_LOOK: begin
        if (sts.scan_done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (next_split) begin
      cmd.scan_go = 1'b1;
      if (!second) begin
        second_next = 1'b1;
        cmd.key_end = 1'b1;
        cmd.scan_op = mrt_pkg::SCAN_FIND;
        state_next  = S_SP_FIND;
      end else begin
        cmd.scan_op = (act == mrt_pkg::ACT_PROT) ? mrt_pkg::SCAN_PROT : mrt_pkg::SCAN_UNMAP;
        state_next  = S_APPLY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      act       <= mrt_pkg::ACT_ADD;
      second    <= 1'b0;
      fail      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      act    <= act_next;
      second <= second_next;
      fail   <= fail_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> in_stall)
    else $error("block not busy after accepting an item");
  a_out_safe: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

endmodule

// ===== src/memory_region_table.sv =====
// top level of the region table: sequencer plus region store datapath
// each item is taken alone; a scan reads and then evaluates each entry in turn and stops at the
// first hit when a single entry is sought; set protection and unmap take up to 7 scans
// the result waits in an output register; the next item is taken once it has been loaded
// synchronous reset clears all valid bits at once; no clearing pass, region fields need none
module memory_region_table #(
  parameter int ENTRIES = mrt_pkg::ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] owner,
  input  logic [63:0] base_addr,
  input  logic [63:0] length,
  input  logic [2:0]  prot,
  input  logic [2:0]  kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic        hit,
  output logic [2:0]  hit_prot,
  output logic [2:0]  hit_kind,
  output logic        is_shared
);

  mrt_pkg::cmd_t cmd;
  mrt_pkg::sts_t sts;

  mrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mrt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .owner     (owner),
    .base_addr (base_addr),
    .length    (length),
    .prot      (prot),
    .kind      (kind),
    .sts       (sts),
    .status    (status),
    .hit       (hit),
    .hit_prot  (hit_prot),
    .hit_kind  (hit_kind),
    .is_shared (is_shared)
  );

endmodule
